// ===== design/wnnm_pkg.sv =====
// Package: shared constants, types and helpers of the nearest-memory neuron.
`timescale 1ns / 1ps
`default_nettype none
package wnnm_pkg;
    localparam int MEM_DEPTH   = 64;
    localparam int PAT_WORDS   = 2;
    localparam int PAT_W       = PAT_WORDS * 64;
    localparam int ADDR_W      = $clog2(MEM_DEPTH);
    localparam int CNT_W       = $clog2(MEM_DEPTH + 1);
    localparam int WC_W        = (PAT_WORDS > 1) ? $clog2(PAT_WORDS) : 1;
    localparam int DIST_W      = $clog2(PAT_W + 2);
    localparam logic [15:0] SEED_DEFAULT = 16'd44257;
    localparam logic [15:0] LFSR_TAPS    = 16'hB400;
    localparam logic [6:0]  REPL_MOD     = 7'd100;
    localparam logic [6:0]  REPL_LIMIT   = 7'd5;
    // ceil(2^23 / 100): exact quotient by 100 for any 16-bit draw, taken from bits [32:23]
    localparam logic [16:0] REPL_RECIP   = 17'd83887;

    // register indexes
    localparam logic [1:0] REG_IN_USE = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_SEED   = 2'd2;

    // output modes
    localparam logic [1:0] MODE_GREY  = 2'd0;
    localparam logic [1:0] MODE_BW    = 2'd1;
    localparam logic [1:0] MODE_COLOR = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOD   = 6'b000010,
        S_SCAN1 = 6'b000100,
        S_SCAN2 = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        K_REPL = 2'd0,
        K_IDX  = 2'd1,
        K_TIE  = 2'd2
    } t_div_kind;

    function automatic logic [15:0] lfsr_next(input logic [15:0] s);
        logic [15:0] t;
        t = {1'b0, s[15:1]};
        if (s[0]) begin
            t = t ^ LFSR_TAPS;
        end
        return t;
    endfunction

    function automatic logic [DIST_W-1:0] popcount(input logic [PAT_W-1:0] x);
        logic [DIST_W-1:0] c;
        c = '0;
        for (int k = 0; k < PAT_W; k++) begin
            c = c + DIST_W'(x[k]);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// ===== design/weightless_neuron_nearest_memory_unit.sv =====
// Top level: VG-RAM neuron memory with nearest-pattern recall and replacement.
`timescale 1ns / 1ps
`default_nettype none
// Channel     | Dir | Handshake               | Carries
// s_axis      | in  | tvalid/tready           | pattern word, value, kind, last word
// m_axis      | out | tvalid/tready           | one result per completed pattern
// apb         | in  | psel/penable/pready=1   | memory_in_use, output_mode, random_seed
//
// Operations: a non-last word is only stored. An append writes its slot. A read runs a first
// scan, a serial remainder for the tie pick and a second scan up to the picked entry. A
// full-memory write takes mod 100 of a draw (reciprocal multiply, then remainder); a random
// slot then needs a serial remainder, the nearest entry both scans and the tie remainder.
// The scan rate is set by the single read port of the pattern memory.
// Reset: synchronous, active low; fill count, LFSR and registers reload, memory is not
// cleared (entries beyond the fill count are never read).
// Stalls: a finished result sits in the output register; a new request is taken while
// it waits, but the next result waits for that register to drain.
module weightless_neuron_nearest_memory_unit
    import wnnm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [71:0] s_axis_tdata,   // [63:0] pattern_word, [71:64] assoc_value
    input  wire         s_axis_tuser,   // [0] req_type
    input  wire         s_axis_tlast,   // word_last
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] result_value, [15:8] best_distance, [21:16] entry_index,
    // [28:22] tie_count, [29] memory_was_empty, [30] replaced_nearest, [31] zero
    output logic [31:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // configuration
    logic [6:0]  r_miu;
    logic [1:0]  r_mode;
    logic [15:0] r_seed;

    // control state
    t_state          r_state;
    logic [15:0]     r_lfsr;
    logic [CNT_W-1:0] r_fill;
    logic [WC_W-1:0] r_wc;
    logic [63:0]     r_pat [PAT_WORDS];
    logic [7:0]      r_val;
    logic            r_is_wr;

    // serial remainder unit
    t_div_kind       r_div_kind;
    logic [15:0]     r_div_num;
    logic [7:0]      r_div_rem;
    logic [6:0]      r_div_den;
    logic [3:0]      r_div_cnt;
    logic [9:0]      r_quo;

    // scan pipeline
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_issue;
    logic             r_v1, r_v2;
    logic [ADDR_W-1:0] r_idx1, r_idx2;
    logic [PAT_W-1:0] r_q_pat;
    logic [7:0]       r_q_val, r_val2;
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_best;
    logic [CNT_W-1:0] r_ties, r_seen, r_pick;

    // result
    logic [7:0]        r_rv;
    logic [ADDR_W-1:0] r_sel;
    logic              r_search, r_empty, r_repl;
    logic              r_out_valid;
    logic [31:0]       r_out_data;

    // memories
    logic [PAT_W-1:0] mem_pat [MEM_DEPTH];
    logic [7:0]       mem_val [MEM_DEPTH];

    logic [CNT_W-1:0] use_n, count;
    logic [15:0]      draw;
    logic [7:0]       div_t, div_step;
    logic [32:0]      repl_prod;
    logic [15:0]      repl_rem;
    logic [PAT_W-1:0] pat_flat;
    logic             s_acc, cfg_wr, mem_we, out_free;

    always_comb begin
        if (r_miu == 7'd0) begin
            use_n = CNT_W'(1);
        end else if (r_miu > 7'(MEM_DEPTH)) begin
            use_n = CNT_W'(MEM_DEPTH);
        end else begin
            use_n = CNT_W'(r_miu);
        end
        count = (r_fill < use_n) ? r_fill : use_n;
        for (int w = 0; w < PAT_WORDS; w++) begin
            pat_flat[w*64 +: 64] = r_pat[w];
        end
    end

    assign draw     = lfsr_next(r_lfsr);
    assign div_t    = {r_div_rem[6:0], r_div_num[15]};
    assign div_step = (div_t >= {1'b0, r_div_den}) ? div_t - {1'b0, r_div_den} : div_t;
    // draw mod 100: quotient by reciprocal multiply, remainder from it in the next cycle
    assign repl_prod = {17'd0, draw} * {16'd0, REPL_RECIP};
    assign repl_rem  = r_div_num - ({6'd0, r_quo} * {9'd0, REPL_MOD});
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign cfg_wr   = psel && penable && pwrite;
    assign mem_we   = (r_state == S_WRITE);
    assign out_free = !r_out_valid || m_axis_tready;
    assign pready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        unique case (paddr[3:2])
            REG_IN_USE: prdata = {25'd0, r_miu};
            REG_MODE:   prdata = {30'd0, r_mode};
            REG_SEED:   prdata = {16'd0, r_seed};
            default:    prdata = 32'd0;
        endcase
    end

    // pattern and value memories: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_pat[r_sel] <= pat_flat;
            mem_val[r_sel] <= r_val;
        end
        r_q_pat <= mem_pat[r_issue[ADDR_W-1:0]];
        r_q_val <= mem_val[r_issue[ADDR_W-1:0]];
    end

    // distance stage (no reset, payload)
    always_ff @(posedge i_clk) begin
        r_dist <= popcount(r_q_pat ^ pat_flat);
        r_idx2 <= r_idx1;
        r_val2 <= r_q_val;
        r_idx1 <= r_issue[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miu       <= 7'd64;
            r_mode      <= MODE_GREY;
            r_seed      <= SEED_DEFAULT;
            r_lfsr      <= SEED_DEFAULT;
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_wc        <= '0;
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            for (int w = 0; w < PAT_WORDS; w++) begin
                r_pat[w] <= '0;
            end
        end else begin
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    REG_IN_USE: r_miu  <= pwdata[6:0];
                    REG_MODE:   r_mode <= pwdata[1:0];
                    REG_SEED: begin
                        r_seed <= pwdata[15:0];
                        r_lfsr <= (pwdata[15:0] == 16'd0) ? SEED_DEFAULT : pwdata[15:0];
                    end
                    default: ;
                endcase
            end

            // scan pipeline valids
            r_v1 <= ((r_state == S_SCAN1) || (r_state == S_SCAN2)) && (r_issue < r_n);
            r_v2 <= r_v1;
            if (r_issue < r_n) begin
                r_issue <= r_issue + CNT_W'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_pat[r_wc] <= s_axis_tdata[63:0];
                        if (!s_axis_tlast) begin
                            r_wc <= (r_wc == WC_W'(PAT_WORDS - 1)) ? '0 : r_wc + WC_W'(1);
                        end else begin
                            r_wc     <= '0;
                            r_val    <= s_axis_tdata[71:64];
                            r_is_wr  <= s_axis_tuser;
                            r_rv     <= 8'd0;
                            r_search <= 1'b0;
                            r_empty  <= 1'b0;
                            r_repl   <= 1'b0;
                            r_sel    <= '0;
                            if (!s_axis_tuser) begin
                                if (count == '0) begin
                                    // empty memory: random value for the mode
                                    r_lfsr  <= draw;
                                    r_empty <= 1'b1;
                                    if (r_mode == MODE_BW) begin
                                        r_rv <= draw[7] ? 8'hFF : 8'h00;
                                    end else if (r_mode == MODE_COLOR) begin
                                        r_rv <= {4'd0, draw[3:0]};
                                    end else begin
                                        r_rv <= draw[7:0];
                                    end
                                    r_state <= S_DONE;
                                end else begin
                                    r_n      <= count;
                                    r_issue  <= '0;
                                    r_best   <= DIST_W'(PAT_W + 1);
                                    r_ties   <= '0;
                                    r_search <= 1'b1;
                                    r_state  <= S_SCAN1;
                                end
                            end else if (r_fill < use_n) begin
                                // append
                                r_sel   <= r_fill[ADDR_W-1:0];
                                r_fill  <= r_fill + CNT_W'(1);
                                r_state <= S_WRITE;
                            end else begin
                                r_lfsr     <= draw;
                                r_div_num  <= draw;
                                r_quo      <= repl_prod[32:23];
                                r_div_kind <= K_REPL;
                                r_state    <= S_MOD;
                            end
                        end
                    end
                end
                S_MOD: begin
                    if (r_div_kind == K_REPL) begin
                        // 5 in 100: replace the nearest entry, else a random one
                        if (repl_rem < 16'(REPL_LIMIT)) begin
                            r_repl   <= 1'b1;
                            r_search <= 1'b1;
                            r_n      <= use_n;
                            r_issue  <= '0;
                            r_best   <= DIST_W'(PAT_W + 1);
                            r_ties   <= '0;
                            r_state  <= S_SCAN1;
                        end else begin
                            r_lfsr     <= draw;
                            r_div_num  <= draw;
                            r_div_rem  <= 8'd0;
                            r_div_den  <= 7'(use_n);
                            r_div_cnt  <= 4'd0;
                            r_div_kind <= K_IDX;
                        end
                    end else begin
                        r_div_rem <= div_step;
                        r_div_num <= {r_div_num[14:0], 1'b0};
                        r_div_cnt <= r_div_cnt + 4'd1;
                        if (r_div_cnt == 4'd15) begin
                            unique case (r_div_kind)
                                K_IDX: begin
                                    r_sel   <= div_step[ADDR_W-1:0];
                                    r_state <= S_WRITE;
                                end
                                default: begin
                                    r_pick  <= CNT_W'(div_step);
                                    r_seen  <= '0;
                                    r_issue <= '0;
                                    r_state <= S_SCAN2;
                                end
                            endcase
                        end
                    end
                end
                S_SCAN1: begin
                    if (r_v2) begin
                        if (r_dist < r_best) begin
                            r_best <= r_dist;
                            r_ties <= CNT_W'(1);
                        end else if (r_dist == r_best) begin
                            r_ties <= r_ties + CNT_W'(1);
                        end
                    end else if (!r_v1 && (r_issue == r_n)) begin
                        r_lfsr     <= draw;
                        r_div_num  <= draw;
                        r_div_rem  <= 8'd0;
                        r_div_den  <= 7'(r_ties);
                        r_div_cnt  <= 4'd0;
                        r_div_kind <= K_TIE;
                        r_state    <= S_MOD;
                    end
                end
                S_SCAN2: begin
                    if (r_v2 && (r_dist == r_best)) begin
                        if (r_seen == r_pick) begin
                            r_sel   <= r_idx2;
                            r_issue <= r_n;
                            if (r_is_wr) begin
                                r_state <= S_WRITE;
                            end else begin
                                r_rv    <= r_val2;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_seen <= r_seen + CNT_W'(1);
                        end
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {1'b0, r_repl, r_empty,
                                        r_search ? 7'(r_ties) : 7'd0,
                                        6'(r_sel),
                                        r_search ? 8'(r_best) : 8'd0,
                                        r_rv};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== test/weightless_neuron_nearest_memory_unit_tb.sv =====
// Testbench: nearest-memory neuron, random and directed requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

// Recall predictor: own copy of entries, fill count, LFSR and registers.
// Results it expects are queued in arrival order.
class neuron_recall_sb;
    logic [63:0] pat_mem [0:wnnm_pkg::MEM_DEPTH*wnnm_pkg::PAT_WORDS-1];
    logic [7:0]  val_mem [0:wnnm_pkg::MEM_DEPTH-1];
    logic [63:0] incoming [0:wnnm_pkg::PAT_WORDS-1];
    int unsigned fill;
    int unsigned word_slot;
    logic [15:0] lfsr;
    logic [6:0]  in_use_reg;
    logic [1:0]  mode_reg;
    logic [31:0] expected_results [$];
    int          mismatches;

    function new();
        fill       = 0;
        word_slot  = 0;
        in_use_reg = 7'd64;
        mode_reg   = wnnm_pkg::MODE_GREY;
        lfsr       = wnnm_pkg::SEED_DEFAULT;
        mismatches = 0;
        foreach (incoming[w]) incoming[w] = '0;
    endfunction

    // Galois step, taps 0xB400; yields the new state
    function logic [15:0] lfsr_step();
        logic lsb;
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) begin
            lfsr = lfsr ^ 16'hB400;
        end
        return lfsr;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] v);
        case (idx)
            wnnm_pkg::REG_IN_USE: in_use_reg = v[6:0];
            wnnm_pkg::REG_MODE:   mode_reg = v[1:0];
            wnnm_pkg::REG_SEED:   lfsr = (v[15:0] == 16'd0) ? wnnm_pkg::SEED_DEFAULT : v[15:0];
            default: ;
        endcase
    endfunction

    function int unsigned hamming(int unsigned e);
        int unsigned d;
        d = 0;
        for (int w = 0; w < wnnm_pkg::PAT_WORDS; w++) begin
            d += $countones(pat_mem[e*wnnm_pkg::PAT_WORDS + w] ^ incoming[w]);
        end
        return d;
    endfunction

    // smallest distance, tie choice by one draw
    function int unsigned nearest(int unsigned cnt, output int unsigned best,
                                  output int unsigned ties);
        int unsigned cur, n, pick, seen, i;
        cur = wnnm_pkg::PAT_W + 1;
        n   = 0;
        for (i = 0; i < cnt; i++) begin
            if (hamming(i) < cur) begin
                cur = hamming(i);
                n   = 1;
            end else if (hamming(i) == cur) begin
                n++;
            end
        end
        pick = lfsr_step() % n;
        seen = 0;
        for (i = 0; i < cnt; i++) begin
            if (hamming(i) == cur) begin
                if (seen == pick) break;
                seen++;
            end
        end
        best = cur;
        ties = n;
        return i;
    endfunction

    function void store(int unsigned e, logic [7:0] v);
        for (int w = 0; w < wnnm_pkg::PAT_WORDS; w++) begin
            pat_mem[e*wnnm_pkg::PAT_WORDS + w] = incoming[w];
        end
        val_mem[e] = v;
    endfunction

    // accepted input word
    function void note_request(logic [71:0] data, logic kind, logic last);
        int unsigned use_n, cnt, best, ties, e, r;
        logic [7:0] rv, bd;
        logic [5:0] idx;
        logic [6:0] tc;
        logic       empty, repl;
        use_n = (in_use_reg == 0) ? 1 :
                (in_use_reg > wnnm_pkg::MEM_DEPTH) ? wnnm_pkg::MEM_DEPTH : in_use_reg;
        cnt   = (fill < use_n) ? fill : use_n;
        rv = '0; bd = '0; idx = '0; tc = '0; empty = 1'b0; repl = 1'b0;
        incoming[word_slot % wnnm_pkg::PAT_WORDS] = data[63:0];
        if (!last) begin
            word_slot = (word_slot + 1) % wnnm_pkg::PAT_WORDS;
            return;
        end
        word_slot = 0;
        if (kind == 1'b0) begin
            if (cnt == 0) begin
                r     = lfsr_step();
                empty = 1'b1;
                if (mode_reg == wnnm_pkg::MODE_BW) rv = ((r % 256) >= 128) ? 8'd255 : 8'd0;
                else if (mode_reg == wnnm_pkg::MODE_COLOR) rv = 8'(r % 16);
                else rv = 8'(r % 256);
            end else begin
                e   = nearest(cnt, best, ties);
                rv  = val_mem[e];
                bd  = 8'(best);
                idx = 6'(e);
                tc  = 7'(ties);
            end
        end else if (fill < use_n) begin
            store(fill, data[71:64]);
            idx = 6'(fill);
            fill++;
        end else if (lfsr_step() % 100 < 5) begin
            e = nearest(use_n, best, ties);
            store(e, data[71:64]);
            idx  = 6'(e);
            bd   = 8'(best);
            tc   = 7'(ties);
            repl = 1'b1;
        end else begin
            e = lfsr_step() % use_n;
            store(e, data[71:64]);
            idx = 6'(e);
        end
        expected_results.push_back({1'b0, repl, empty, tc, idx, bd, rv});
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] exp_r;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = expected_results.pop_front();
        if (got[7:0] !== exp_r[7:0] || got[15:8] !== exp_r[15:8] ||
            got[21:16] !== exp_r[21:16] || got[28:22] !== exp_r[28:22] ||
            got[29] !== exp_r[29] || got[30] !== exp_r[30] || got[31] !== exp_r[31]) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch exp/got: v %0d/%0d d %0d/%0d i %0d/%0d t %0d/%0d e %b/%b r %b/%b",
                         exp_r[7:0], got[7:0], exp_r[15:8], got[15:8], exp_r[21:16], got[21:16],
                         exp_r[28:22], got[28:22], exp_r[29], got[29], exp_r[30], got[30]);
            end
        end
    endfunction
endclass

module weightless_neuron_nearest_memory_unit_tb;
    import wnnm_pkg::*;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT = 3_000_000;
    localparam int   DRAIN_CYCLES = 200;   // longest scan plus replacement passes

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;     // [63:0] pattern_word, [71:64] assoc_value
    logic        s_axis_tuser = 1'b0;   // [0] req_type
    logic        s_axis_tlast = 1'b0;   // word_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] result_value, [15:8] best_distance, [21:16] entry_index,
    // [28:22] tie_count, [29] memory_was_empty, [30] replaced_nearest, [31] zero
    logic [31:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    weightless_neuron_nearest_memory_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    neuron_recall_sb recall_sb = new();

    int unsigned send_idle_pct = 0;    // chance per cycle that the sender idles
    int unsigned recv_stall_pct = 0;   // chance per cycle that the receiver stalls
    longint unsigned cycles = 0;
    logic [63:0] pattern_pool [0:7][0:1];   // seeds of near-duplicate patterns

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // request acceptance, result check, receiver stalls and the watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            recall_sb.note_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            recall_sb.check_result(m_axis_tdata);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // APB write: setup then access; the register takes it when pready is high
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        recall_sb.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // one input word; valid stays high back to back unless an idle cycle is drawn
    task automatic send_word(input logic [63:0] w, input logic [7:0] v,
                             input logic kind, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, w};
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // config only when idle: results drained plus the longest operation
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (recall_sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] make_word(int unsigned p, int unsigned slot);
        logic [63:0] w;
        case ($urandom_range(9))
            0: w = '0;
            1: w = '1;
            2: w = {$urandom, $urandom};
            default: begin
                w = pattern_pool[p][slot];
                repeat ($urandom_range(3)) w[$urandom_range(63)] ^= 1'b1;
            end
        endcase
        return w;
    endfunction

    // kind and value on non-last words are don't-care, so they are random
    task automatic send_pattern(input logic kind, input int unsigned nwords);
        int unsigned p;
        p = $urandom_range(7);
        for (int s = 0; s < nwords; s++) begin
            if (s == nwords - 1) send_word(make_word(p, s % 2), 8'($urandom), kind, 1'b1);
            else send_word(make_word(p, s % 2), 8'($urandom), 1'($urandom), 1'b0);
        end
    endtask

    int unsigned phase_in_use [0:6] = '{3, 64, 1, 127, 0, 8, 2};
    int unsigned phase_mode   [0:6] = '{MODE_GREY, MODE_BW, MODE_COLOR, 3, MODE_GREY,
                                        MODE_COLOR, MODE_BW};
    int unsigned phase_seed   [0:6] = '{0, 0, 65535, 1, 0, 0, 0};
    int unsigned idle_mix     [0:3][0:1] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{23, 23}};

    initial begin
        int unsigned sent, nw;
        foreach (pattern_pool[p, s]) pattern_pool[p][s] = {$urandom, $urandom};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty memory: random output under every mode, the unknown one included
        for (int m = 0; m < 4; m++) begin
            reg_write(REG_MODE, m);
            send_word(64'($urandom), 8'($urandom), REQ_READ, 1'b1);
            settle();
        end

        // small memory: extremes, ties, odd pattern lengths, then replacement
        reg_write(REG_IN_USE, 4);
        reg_write(REG_SEED, 1);
        send_word('0, 8'd0, REQ_WRITE, 1'b0);   send_word('0, 8'd0, REQ_WRITE, 1'b1);
        send_word('1, 8'd255, REQ_WRITE, 1'b0); send_word('1, 8'd255, REQ_WRITE, 1'b1);
        send_word('0, 8'd7, REQ_WRITE, 1'b0);   send_word('0, 8'd7, REQ_WRITE, 1'b1);
        send_word('0, 8'd1, REQ_READ, 1'b0);    send_word('0, 8'd1, REQ_READ, 1'b1);
        send_word('1, 8'd0, REQ_READ, 1'b0);    send_word('1, 8'd0, REQ_READ, 1'b1);
        send_word('0, 8'd0, REQ_READ, 1'b0);    send_word('1, 8'd0, REQ_READ, 1'b1);
        // single word: slot 1 keeps the previous contents
        send_word(64'h0123_4567_89ab_cdef, 8'h5a, REQ_WRITE, 1'b1);
        // three words: slot 0 is overwritten on wrap
        send_word('1, 8'd3, REQ_READ, 1'b0);
        send_word('0, 8'd3, REQ_READ, 1'b0);
        send_word(64'hffff_0000_ffff_0000, 8'd3, REQ_WRITE, 1'b1);
        send_word('1, 8'd9, REQ_WRITE, 1'b0);   send_word('0, 8'd9, REQ_WRITE, 1'b1);
        settle();

        // random phases over register settings and idle mixes
        for (int ph = 0; ph < 7; ph++) begin
            reg_write(REG_IN_USE, phase_in_use[ph]);
            reg_write(REG_MODE, phase_mode[ph]);
            reg_write(REG_SEED, (ph == 0 || ph >= 4) ? $urandom_range(65535) : phase_seed[ph]);
            send_idle_pct  = idle_mix[ph % 4][0];
            recv_stall_pct = idle_mix[ph % 4][1];
            sent = 0;
            while (sent < 236) begin
                // mostly whole two-word patterns, some short or wrapping ones
                nw = ($urandom_range(99) < 8) ? $urandom_range(1, 3) : 2;
                send_pattern(1'($urandom_range(1)), nw);
                sent += nw;
                if ($urandom_range(49) == 0) begin
                    pattern_pool[$urandom_range(7)][$urandom_range(1)] = {$urandom, $urandom};
                end
            end
            settle();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        if (recall_sb.mismatches == 0 && recall_sb.expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

`default_nettype wire
